// File: src/ppt_pkg.sv
// Shared types, constants and the CORDIC angle table for the pure pursuit twist block.
// No dependencies; every other file but ppt_delay refers to this package by scoped names.

package ppt_pkg;

    // Default and fixed pipeline depths.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SQRT_STAGES       = 32;
    localparam int SQRT_LATENCY      = SQRT_STAGES + 2;

    // Datapath widths.
    localparam int CW     = 36;  // CORDIC x/y width, holds the gain growth of a 33-bit vector
    localparam int ZW     = 34;  // CORDIC angle accumulator, Q2.30 plus headroom
    localparam int AW     = 16;  // Q3.13 angle output
    localparam int ADDR_W = 5;

    localparam logic signed [AW-1:0] ANG_LIMIT   = 16'sd25736;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [31:0]   SAT_POS     = 32'sh7FFF_FFFF;

    // Register word indexes on the configuration port.
    localparam logic [2:0] REG_SPEED_GAIN    = 3'd0;
    localparam logic [2:0] REG_ROTATION_GAIN = 3'd1;
    localparam logic [2:0] REG_SPIN_THRESH   = 3'd2;
    localparam logic [2:0] REG_SPIN_SPEED    = 3'd3;
    localparam logic [2:0] REG_SPIN_ROT      = 3'd4;

    // Register reset values.
    localparam logic [15:0] RST_SPEED_GAIN    = 16'd256;
    localparam logic [15:0] RST_ROTATION_GAIN = 16'd256;
    localparam logic [14:0] RST_SPIN_THRESH   = 15'd8192;
    localparam logic [15:0] RST_SPIN_SPEED    = 16'd655;
    localparam logic [15:0] RST_SPIN_ROT      = 16'd52429;

    typedef logic signed [31:0]   t_q16;
    typedef logic signed [AW-1:0] t_angle;

    typedef struct packed {
        t_q16 route_x;
        t_q16 route_y;
        t_q16 plan_x;
        t_q16 plan_y;
    } t_in_item;

    typedef struct packed {
        t_q16 linear_speed;
        t_q16 angular_rate;
        logic spinning;
    } t_out_item;

    // Elementary rotation angle of CORDIC step i, Q2.30 radians.
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 34'sd843314857;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043837;
            3:  a = 34'sd133525159;
            4:  a = 34'sd67021687;
            5:  a = 34'sd33543516;
            6:  a = 34'sd16775851;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194283;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048576;
            11: a = 34'sd524288;
            default: begin
                if (i <= 30) begin
                    a = ZW'(34'sd1 <<< (30 - i));
                end else begin
                    a = '0;
                end
            end
        endcase
        return a;
    endfunction

endpackage

// File: src/pure_pursuit_twist_command.sv
// Top level of the pure pursuit twist command block: register port, pipeline control,
// speed and rate products, output register with skid. Uses ppt_pkg, ppt_cordic,
// ppt_isqrt and ppt_delay.
//
//   port group                          | dir | transfer when
//   i_valid / o_stall / i_data          | in  | i_valid high and o_stall low
//   o_valid / i_stall / o_data          | out | o_valid high and i_stall low
//   psel penable pwrite paddr pwdata    | cfg | psel, penable, pwrite high (pready is 1)
//
// One goal pair enters per clock while o_stall is low; its result passes the square root
// pipeline, stages A, B and C and the output register before o_valid rises for it.
// The latency is set by the 32-step square root pipeline; the CORDIC angles are
// delayed to meet it, so CORDIC_STAGES does not change it.
// i_rst_n is synchronous and active low; it clears valid state and the configuration registers.
// o_stall comes from a register: it rises only once the skid stage holds a result,
// and then the whole pipeline holds until the skid result moves to the output register.

module pure_pursuit_twist_command #(
    parameter int CORDIC_STAGES = ppt_pkg::CORDIC_STAGES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  ppt_pkg::t_in_item          i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output ppt_pkg::t_out_item         o_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ppt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int FRONT = ppt_pkg::SQRT_LATENCY;
    localparam int ALIGN = ppt_pkg::SQRT_LATENCY - (CORDIC_STAGES + 2);

    // ---------------- configuration registers ----------------
    logic [15:0] r_speed_gain;
    logic [15:0] r_rotation_gain;
    logic [14:0] r_spin_threshold;
    logic [15:0] r_spin_speed_factor;
    logic [15:0] r_spin_rotation_factor;
    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];

    // A write to a word beyond the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain           <= ppt_pkg::RST_SPEED_GAIN;
            r_rotation_gain        <= ppt_pkg::RST_ROTATION_GAIN;
            r_spin_threshold       <= ppt_pkg::RST_SPIN_THRESH;
            r_spin_speed_factor    <= ppt_pkg::RST_SPIN_SPEED;
            r_spin_rotation_factor <= ppt_pkg::RST_SPIN_ROT;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                ppt_pkg::REG_SPEED_GAIN:    r_speed_gain           <= pwdata[15:0];
                ppt_pkg::REG_ROTATION_GAIN: r_rotation_gain        <= pwdata[15:0];
                ppt_pkg::REG_SPIN_THRESH:   r_spin_threshold       <= pwdata[14:0];
                ppt_pkg::REG_SPIN_SPEED:    r_spin_speed_factor    <= pwdata[15:0];
                ppt_pkg::REG_SPIN_ROT:      r_spin_rotation_factor <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (w_cfg_idx)
            ppt_pkg::REG_SPEED_GAIN:    prdata = {16'b0, r_speed_gain};
            ppt_pkg::REG_ROTATION_GAIN: prdata = {16'b0, r_rotation_gain};
            ppt_pkg::REG_SPIN_THRESH:   prdata = {17'b0, r_spin_threshold};
            ppt_pkg::REG_SPIN_SPEED:    prdata = {16'b0, r_spin_speed_factor};
            ppt_pkg::REG_SPIN_ROT:      prdata = {16'b0, r_spin_rotation_factor};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic r_skid_valid;
    logic r_out_valid;
    logic w_adv;

    // The pipeline moves whenever the skid stage is empty.
    assign w_adv   = !r_skid_valid;
    assign o_stall = r_skid_valid;

    logic r_fv [0:FRONT-1];
    logic r_va;
    logic r_vb;
    logic r_vc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRONT; i++) begin
                r_fv[i] <= 1'b0;
            end
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (w_adv) begin
            r_fv[0] <= i_valid;
            for (int i = 1; i < FRONT; i++) begin
                r_fv[i] <= r_fv[i-1];
            end
            r_va <= r_fv[FRONT-1];
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // ---------------- angle and distance units ----------------
    ppt_pkg::t_angle w_head_raw;
    ppt_pkg::t_angle w_bear_raw;
    ppt_pkg::t_angle w_head;
    ppt_pkg::t_angle w_bear;
    logic [31:0]     w_dist;

    ppt_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_route_cordic (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x     (i_data.route_x),
        .i_y     (i_data.route_y),
        .o_angle (w_head_raw)
    );

    ppt_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_plan_cordic (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x     (i_data.plan_x),
        .i_y     (i_data.plan_y),
        .o_angle (w_bear_raw)
    );

    ppt_isqrt u_plan_dist (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (i_data.plan_x),
        .i_y    (i_data.plan_y),
        .o_root (w_dist)
    );

    ppt_delay #(
        .DEPTH (ALIGN),
        .WIDTH (2 * ppt_pkg::AW)
    ) u_angle_align (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({w_head_raw, w_bear_raw}),
        .o_q   ({w_head, w_bear})
    );

    // ---------------- stage A: branch choice and operand select ----------------
    logic [14:0] w_ahead;
    logic [14:0] w_abear;
    logic        w_spin;
    logic        r_a_spin;
    logic        r_a_neg;
    logic [31:0] r_a_mul_b;
    logic [15:0] r_a_mul_d;

    assign w_ahead = w_head[ppt_pkg::AW-1] ? 15'(-w_head) : w_head[14:0];
    assign w_abear = w_bear[ppt_pkg::AW-1] ? 15'(-w_bear) : w_bear[14:0];
    assign w_spin  = w_ahead > r_spin_threshold;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_spin  <= w_spin;
            r_a_neg   <= w_spin ? w_head[ppt_pkg::AW-1] : w_bear[ppt_pkg::AW-1];
            r_a_mul_b <= w_spin ? {16'b0, r_spin_speed_factor} : w_dist;
            r_a_mul_d <= w_spin ? r_spin_rotation_factor : {1'b0, w_abear};
        end
    end

    // ---------------- stage B: gain products ----------------
    logic [47:0] r_b_p1;
    logic [31:0] r_b_p2;
    logic        r_b_spin;
    logic        r_b_neg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_p1   <= 48'(r_speed_gain) * 48'(r_a_mul_b);
            r_b_p2   <= 32'(r_rotation_gain) * 32'(r_a_mul_d);
            r_b_spin <= r_a_spin;
            r_b_neg  <= r_a_neg;
        end
    end

    // ---------------- stage C: scaling, saturation and sign ----------------
    ppt_pkg::t_q16      w_speed;
    logic [26:0]        w_rot_mag;
    ppt_pkg::t_q16      w_rot_pos;
    ppt_pkg::t_out_item r_c_item;

    // Speed is the product over 256, limited to the largest positive word.
    assign w_speed = (|r_b_p1[47:39]) ? ppt_pkg::SAT_POS : $signed({1'b0, r_b_p1[38:8]});

    // The rate magnitude stays below 2^27, so it never reaches the limit.
    assign w_rot_mag = r_b_spin ? {3'b0, r_b_p2[31:8]} : r_b_p2[31:5];
    assign w_rot_pos = $signed({5'b0, w_rot_mag});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_item.linear_speed <= w_speed;
            r_c_item.angular_rate <= r_b_neg ? -w_rot_pos : w_rot_pos;
            r_c_item.spinning     <= r_b_spin;
        end
    end

    // ---------------- output register and skid stage ----------------
    ppt_pkg::t_out_item r_out_item;
    ppt_pkg::t_out_item r_skid_item;
    logic               w_out_free;
    logic               w_push;
    logic               n_out_valid;
    logic               n_skid_valid;
    logic               w_load_skid_out;
    logic               w_load_pipe_out;
    logic               w_load_skid;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_push     = r_vc && w_adv;

    always_comb begin
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        w_load_skid_out = 1'b0;
        w_load_pipe_out = 1'b0;
        w_load_skid     = 1'b0;
        if (w_out_free) begin
            if (r_skid_valid) begin
                n_out_valid     = 1'b1;
                n_skid_valid    = 1'b0;
                w_load_skid_out = 1'b1;
            end else if (w_push) begin
                n_out_valid     = 1'b1;
                w_load_pipe_out = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_push) begin
            n_skid_valid = 1'b1;
            w_load_skid  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_skid_out) begin
            r_out_item <= r_skid_item;
        end else if (w_load_pipe_out) begin
            r_out_item <= r_c_item;
        end
        if (w_load_skid) begin
            r_skid_item <= r_c_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_item;

    // ---------------- assertions ----------------
    a_skid_only_behind_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid
    ) else $error("skid stage holds a result while the output register is empty");

    a_skid_drains: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid)
    ) else $error("skid result was not moved to the output register");

    a_spin_speed_small: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.spinning) |-> (o_data.linear_speed[31:24] == 8'b0)
    ) else $error("spin speed exceeds the range of its gain product");

    a_track_rate_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.spinning) |->
            (o_data.angular_rate[31:26] == 6'b000000 || o_data.angular_rate[31:26] == 6'b111111)
    ) else $error("tracking rate outside the range of gain times bearing");

endmodule

// File: src/ppt_cordic.sv
// Pipelined CORDIC vectoring unit: atan2 of a Q16.16 point, rounded to Q3.13 radians.
// Depends on ppt_pkg for widths, the angle table and the angle limit.

module ppt_cordic #(
    parameter int STAGES = ppt_pkg::CORDIC_STAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  ppt_pkg::t_q16  i_x,
    input  ppt_pkg::t_q16  i_y,
    output ppt_pkg::t_angle o_angle
);

    logic signed [ppt_pkg::CW-1:0] r_x [0:STAGES];
    logic signed [ppt_pkg::CW-1:0] r_y [0:STAGES];
    logic signed [ppt_pkg::ZW-1:0] r_z [0:STAGES];
    logic                          r_zero [0:STAGES];
    ppt_pkg::t_angle               r_angle;

    logic signed [ppt_pkg::CW-1:0] n_x0;
    logic signed [ppt_pkg::CW-1:0] n_y0;
    logic signed [ppt_pkg::ZW-1:0] n_z0;

    // Points left of the y axis are turned by a quarter turn first.
    always_comb begin
        n_x0 = ppt_pkg::CW'(i_x);
        n_y0 = ppt_pkg::CW'(i_y);
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = ppt_pkg::CW'(i_y);
                n_y0 = -ppt_pkg::CW'(i_x);
                n_z0 = ppt_pkg::HALF_PI_Q30;
            end else begin
                n_x0 = -ppt_pkg::CW'(i_y);
                n_y0 = ppt_pkg::CW'(i_x);
                n_z0 = -ppt_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < STAGES; i++) begin : g_step
        localparam logic signed [ppt_pkg::ZW-1:0] ANG = ppt_pkg::atan_q30(i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ANG;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ANG;
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    logic signed [ppt_pkg::ZW-1:0] w_z_rnd;
    ppt_pkg::t_angle               w_z_clamp;

    // Round to nearest with ties up into Q3.13, then clamp to plus or minus pi.
    always_comb begin
        w_z_rnd = (r_z[STAGES] + ppt_pkg::ZW'(65536)) >>> 17;
        if (w_z_rnd > ppt_pkg::ZW'(ppt_pkg::ANG_LIMIT)) begin
            w_z_clamp = ppt_pkg::ANG_LIMIT;
        end else if (w_z_rnd < -ppt_pkg::ZW'(ppt_pkg::ANG_LIMIT)) begin
            w_z_clamp = -ppt_pkg::ANG_LIMIT;
        end else begin
            w_z_clamp = ppt_pkg::AW'(w_z_rnd);
        end
    end

    // The origin has no direction; it reads as angle zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_zero[STAGES] ? '0 : w_z_clamp;
        end
    end

    assign o_angle = r_angle;

endmodule

// File: src/ppt_isqrt.sv
// Pipelined Euclidean distance: squares, sum, then an exact floor square root one bit per stage.
// Depends on ppt_pkg for the stage count and the Q16.16 type.

module ppt_isqrt (
    input  logic          i_clk,
    input  logic          i_en,
    input  ppt_pkg::t_q16 i_x,
    input  ppt_pkg::t_q16 i_y,
    output logic [31:0]   o_root
);

    localparam int N = ppt_pkg::SQRT_STAGES;

    logic signed [63:0] r_sqx;
    logic signed [63:0] r_sqy;
    logic [63:0]        r_v [0:N];
    logic [63:0]        r_r [0:N];

    logic signed [63:0] w_sqx;
    logic signed [63:0] w_sqy;

    // A signed square equals the square of the magnitude.
    assign w_sqx = 64'(i_x) * 64'(i_x);
    assign w_sqy = 64'(i_y) * 64'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx  <= w_sqx;
            r_sqy  <= w_sqy;
            r_v[0] <= $unsigned(r_sqx) + $unsigned(r_sqy);
            r_r[0] <= '0;
        end
    end

    // Restoring square root: stage k tries the result bit of weight 2^(31-k).
    for (genvar k = 0; k < N; k++) begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_trial;
        assign w_trial = r_r[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_v[k] >= w_trial) begin
                    r_v[k+1] <= r_v[k] - w_trial;
                    r_r[k+1] <= (r_r[k] >> 1) + BIT;
                end else begin
                    r_v[k+1] <= r_v[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
            end
        end
    end

    assign o_root = r_r[N][31:0];

endmodule

// File: src/ppt_delay.sv
// Enabled shift line that brings the CORDIC angles in step with the distance pipeline.
// No package dependencies.

module ppt_delay #(
    parameter int DEPTH = 1,
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    if (DEPTH == 0) begin : g_none
        assign o_q = i_d;
    end else begin : g_line
        logic [WIDTH-1:0] r_line [0:DEPTH-1];

        // Each enabled cycle moves every tap one place along.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_line[0] <= i_d;
                for (int i = 1; i < DEPTH; i++) begin
                    r_line[i] <= r_line[i-1];
                end
            end
        end

        assign o_q = r_line[DEPTH-1];
    end

endmodule

// File: verif/pure_pursuit_twist_command_test.sv
// Self-checking testbench for pure_pursuit_twist_command: directed goal pairs, register sweeps,
// random traffic with idling and back-pressure, each result checked against a local predictor.
// Depends on ppt_pkg and the RTL of the block only.

module pure_pursuit_twist_command_test;

    localparam int      STAGES        = ppt_pkg::CORDIC_STAGES_DEF;
    localparam int      PIPE_LATENCY  = 38;
    localparam int      END_WAIT      = 2 * PIPE_LATENCY;
    localparam int      QUIET_LIMIT   = 2000;
    localparam int      HOLD_CYCLES   = 400;
    localparam int      MAX_REPORTS   = 10;
    localparam longint  QUARTER_TURN  = 64'sd1686629713;
    localparam longint  ANGLE_CLAMP   = 64'sd25736;
    localparam longint  SAT_MAG       = 64'sd2147483647;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    ppt_pkg::t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    ppt_pkg::t_out_item o_data;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    logic [ppt_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic      pready;

    // Register shadow copies used by the predictor.
    logic [15:0] cfg_speed_gain = ppt_pkg::RST_SPEED_GAIN;
    logic [15:0] cfg_rotation_gain = ppt_pkg::RST_ROTATION_GAIN;
    logic [14:0] cfg_spin_thresh = ppt_pkg::RST_SPIN_THRESH;
    logic [15:0] cfg_spin_speed = ppt_pkg::RST_SPIN_SPEED;
    logic [15:0] cfg_spin_rot = ppt_pkg::RST_SPIN_ROT;

    ppt_pkg::t_out_item expected_twists[$];
    int        n_mismatch = 0;
    int        quiet_cycles = 0;
    bit        tx_idle_on = 1'b0;
    bit        rx_idle_on = 1'b0;
    bit        hold_req = 1'b0;
    int        hold_left = 0;
    int        rx_burst = 0;

    pure_pursuit_twist_command #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Elementary CORDIC rotation angles in Q2.30 radians.
    function automatic longint step_angle(input int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            10: return 1048576;
            11: return 524288;
            default: return (i <= 30) ? (longint'(1) << (30 - i)) : 0;
        endcase
    endfunction

    // Vectoring CORDIC atan2 of a point, rounded to Q3.13 and clamped to +/-pi.
    function automatic longint cordic_heading(input longint px, input longint py);
        longint x, y, z, nx, ny, t;
        int i;
        if (px == 0 && py == 0) begin
            return 0;
        end
        x = px;
        y = py;
        z = 0;
        // Points behind the robot are first turned by a quarter turn.
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = QUARTER_TURN;
            end else begin
                t = x; x = -y; y = t; z = -QUARTER_TURN;
            end
        end
        for (i = 0; i < STAGES && i < 32; i++) begin
            if (y < 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - step_angle(i);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + step_angle(i);
            end
            x = nx;
            y = ny;
        end
        z = (z + 65536) >>> 17;
        if (z > ANGLE_CLAMP) z = ANGLE_CLAMP;
        if (z < -ANGLE_CLAMP) z = -ANGLE_CLAMP;
        return z;
    endfunction

    // Exact integer square root, rounded down.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root, probe;
        root = 0;
        probe = 64'h1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Saturate a magnitude to the positive Q16.16 range, then apply the sign.
    function automatic ppt_pkg::t_q16 clip_signed(input longint unsigned mag, input bit neg);
        logic [63:0] word;
        if (mag > SAT_MAG) mag = SAT_MAG;
        word = neg ? (64'd0 - mag) : mag;
        return word[31:0];
    endfunction

    // Twist command that the block should produce for one goal pair.
    function automatic ppt_pkg::t_out_item predict_twist(input ppt_pkg::t_in_item g);
        longint head, bear, px, py;
        longint unsigned ahead, abear, ax, ay, plan_dist;
        ppt_pkg::t_out_item r;
        head  = cordic_heading(longint'(g.route_x), longint'(g.route_y));
        ahead = (head < 0) ? -head : head;
        if (ahead > longint'(cfg_spin_thresh)) begin
            r.linear_speed = clip_signed((longint'(cfg_speed_gain) * cfg_spin_speed) >> 8, 1'b0);
            r.angular_rate = clip_signed((longint'(cfg_rotation_gain) * cfg_spin_rot) >> 8,
                                         head < 0);
            r.spinning = 1'b1;
        end else begin
            px        = longint'(g.plan_x);
            py        = longint'(g.plan_y);
            ax        = (px < 0) ? -px : px;
            ay        = (py < 0) ? -py : py;
            plan_dist = floor_sqrt(ax * ax + ay * ay);
            bear      = cordic_heading(px, py);
            abear     = (bear < 0) ? -bear : bear;
            r.linear_speed = clip_signed((longint'(cfg_speed_gain) * plan_dist) >> 8, 1'b0);
            r.angular_rate = clip_signed((longint'(cfg_rotation_gain) * abear) >> 5, bear < 0);
            r.spinning = 1'b0;
        end
        return r;
    endfunction

    function automatic ppt_pkg::t_in_item goal(input ppt_pkg::t_q16 rx, input ppt_pkg::t_q16 ry,
                                               input ppt_pkg::t_q16 px, input ppt_pkg::t_q16 py);
        ppt_pkg::t_in_item g;
        g.route_x = rx;
        g.route_y = ry;
        g.plan_x  = px;
        g.plan_y  = py;
        return g;
    endfunction

    // One coordinate drawn from a mix of full-range, scaled, small and edge values.
    function automatic ppt_pkg::t_q16 rand_coord();
        ppt_pkg::t_q16 v;
        case ($urandom_range(0, 7))
            0:       v = $signed($urandom) >>> $urandom_range(0, 31);
            1:       v = $signed($urandom) >>> $urandom_range(8, 20);
            2:       v = 32'sh7FFF_FFFF;
            3:       v = 32'sh8000_0000;
            4:       v = $urandom_range(0, 2) - 1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic ppt_pkg::t_in_item rand_goal();
        return goal(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    task automatic flag_error(input string msg);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Write one register over the configuration port and update its shadow copy.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] word);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ppt_pkg::ADDR_W'({idx, 2'b00});
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            ppt_pkg::REG_SPEED_GAIN:    cfg_speed_gain = word[15:0];
            ppt_pkg::REG_ROTATION_GAIN: cfg_rotation_gain = word[15:0];
            ppt_pkg::REG_SPIN_THRESH:   cfg_spin_thresh = word[14:0];
            ppt_pkg::REG_SPIN_SPEED:    cfg_spin_speed = word[15:0];
            ppt_pkg::REG_SPIN_ROT:      cfg_spin_rot = word[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Field value in the low bits, random junk above the register width.
    task automatic write_field(input logic [2:0] idx, input logic [15:0] value);
        logic [31:0] word;
        word = $urandom;
        if (idx == ppt_pkg::REG_SPIN_THRESH) begin
            word[14:0] = value[14:0];
        end else begin
            word[15:0] = value;
        end
        write_reg(idx, word);
    endtask

    task automatic set_config(input logic [15:0] sg, input logic [15:0] rg,
                              input logic [14:0] th, input logic [15:0] ss,
                              input logic [15:0] sr);
        write_field(ppt_pkg::REG_SPEED_GAIN, sg);
        write_field(ppt_pkg::REG_ROTATION_GAIN, rg);
        write_field(ppt_pkg::REG_SPIN_THRESH, {1'b0, th});
        write_field(ppt_pkg::REG_SPIN_SPEED, ss);
        write_field(ppt_pkg::REG_SPIN_ROT, sr);
    endtask

    // Offer one goal pair and hold it until the transfer happens.
    task automatic send_goal(input ppt_pkg::t_in_item g);
        int gap;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid = 1'b0;
            i_data  = {$urandom, $urandom, $urandom, $urandom};
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = g;
        do @(posedge i_clk); while (o_stall);
        expected_twists.push_back(predict_twist(g));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_goal(rand_goal());
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_twists.size() != 0) @(posedge i_clk);
    endtask

    // Axes, quadrants, the origin, the negative x axis and saturating distances.
    task automatic test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_goal(goal(0, 0, 0, 0));
        send_goal(goal(32'sd65536, 0, 32'sd65536, 0));
        send_goal(goal(-32'sd65536, 0, 32'sd65536, 32'sd65536));
        send_goal(goal(32'sh8000_0000, 0, 0, 0));
        send_goal(goal(0, 32'sd65536, 0, 0));
        send_goal(goal(0, -32'sd65536, 0, 0));
        send_goal(goal(-32'sd65536, -32'sd65536, 0, 0));
        send_goal(goal(-32'sd65536, 32'sd65536, 0, 0));
        send_goal(goal(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_goal(goal(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh8000_0000));
        send_goal(goal(32'sd65536, 0, 32'sh8000_0000, 0));
        send_goal(goal(32'sd65536, 0, 0, 32'sh8000_0000));
        send_goal(goal(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
        send_goal(goal(32'sd1, 32'sh8000_0000, 0, 0));
        send_goal(goal(32'sh7FFF_FFFF, -32'sd1, -32'sd1, -32'sd1));
        send_goal(goal(32'sd100, 32'sd1, -32'sd1, 0));
        send_goal(goal(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000));
        send_goal(goal(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_goal(goal(32'sd1, 0, 0, 32'sd1));
        send_goal(goal(-32'sd1, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_goal(goal(32'sd3 << 16, -32'sd5 << 16, 32'sd2 << 16, -32'sd7 << 16));
        wait_drained();
    endtask

    // A heading equal to the threshold tracks; one above it spins.
    task automatic test_threshold_edge();
        ppt_pkg::t_in_item pts[2];
        longint h;
        pts[0] = goal(32'sd3 << 16, 32'sd2 << 16, 32'sd5 << 16, 32'sd1 << 16);
        pts[1] = goal(32'sd1 << 16, -32'sd4 << 16, -32'sd2 << 16, 32'sd3 << 16);
        foreach (pts[k]) begin
            h = cordic_heading(longint'(pts[k].route_x), longint'(pts[k].route_y));
            if (h < 0) h = -h;
            write_field(ppt_pkg::REG_SPIN_THRESH, 16'(h));
            send_goal(pts[k]);
            wait_drained();
            write_field(ppt_pkg::REG_SPIN_THRESH, 16'(h - 1));
            send_goal(pts[k]);
            wait_drained();
        end
    endtask

    // Registers at their extremes, and a write to an unused address.
    task automatic test_register_extremes();
        set_config(16'hFFFF, 16'hFFFF, 15'd25736, 16'hFFFF, 16'hFFFF);
        send_random(30);
        wait_drained();
        set_config(16'h0000, 16'h0000, 15'd0, 16'h0000, 16'h0000);
        send_random(30);
        wait_drained();
        set_config(16'hFFFF, 16'hFFFF, 15'd0, 16'hFFFF, 16'hFFFF);
        write_reg(REG_UNUSED, $urandom);
        send_random(30);
        wait_drained();
    endtask

    // Reset register values, then random settings, each followed by a batch of random goal pairs.
    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            if (p == 0) begin
                set_config(ppt_pkg::RST_SPEED_GAIN, ppt_pkg::RST_ROTATION_GAIN,
                           ppt_pkg::RST_SPIN_THRESH, ppt_pkg::RST_SPIN_SPEED,
                           ppt_pkg::RST_SPIN_ROT);
            end else begin
                set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           15'($urandom_range(0, 25736)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
            end
            tx_idle_on = (p != 3);
            rx_idle_on = (p != 3) && (p != 4);
            send_random(150);
            wait_drained();
        end
    endtask

    // The receiver holds off for a long stretch while goal pairs keep coming.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        @(negedge i_clk);
        hold_req = 1'b1;
        send_random(100);
        wait_drained();
    endtask

    // The sender pauses until every result is back, then resumes.
    task automatic test_drain_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_random(30);
        wait_drained();
        send_random(30);
        wait_drained();
    endtask

    // Closing stretch without idling on either side.
    task automatic test_steady();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   15'($urandom_range(0, 25736)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
        send_random(100);
        wait_drained();
    endtask

    // Receiver stall: long hold-off on request, otherwise random bursts.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (rx_burst > 0) begin
            i_stall = 1'b1;
            rx_burst--;
        end else begin
            i_stall = 1'b0;
            if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                rx_burst = $urandom_range(1, 15);
            end
        end
    end

    // Compare each result transfer with the oldest expected twist.
    always @(posedge i_clk) begin
        ppt_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_twists.size() == 0) begin
                flag_error($sformatf("unexpected result: speed %0d rate %0d spin %0b",
                                     o_data.linear_speed, o_data.angular_rate,
                                     o_data.spinning));
            end else begin
                want = expected_twists.pop_front();
                if (o_data.linear_speed !== want.linear_speed ||
                    o_data.angular_rate !== want.angular_rate ||
                    o_data.spinning !== want.spinning) begin
                    flag_error($sformatf(
                        "mismatch: expected speed %0d rate %0d spin %0b, got %0d %0d %0b",
                        want.linear_speed, want.angular_rate, want.spinning,
                        o_data.linear_speed, o_data.angular_rate, o_data.spinning));
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("pure_pursuit_twist_command test failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_threshold_edge();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        test_drain_pause();
        test_steady();
        repeat (END_WAIT) @(posedge i_clk);
        if (n_mismatch == 0 && expected_twists.size() == 0) begin
            $display("pure_pursuit_twist_command test passed");
        end else begin
            $display("pure_pursuit_twist_command test failed");
        end
        $finish;
    end

endmodule
